[design/bsd_pkg.sv]
package bsd_pkg;

  // default coordinate width (signed fixed point)
  localparam int COORD_WIDTH_DEF = 32;

  // configuration register index width and codes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_X = 3'd0,
    REG_CORNER_Y = 3'd1,
    REG_CORNER_Z = 3'd2,
    REG_EXTENT_X = 3'd3,
    REG_EXTENT_Y = 3'd4,
    REG_EXTENT_Z = 3'd5
  } cfg_reg_t;

endpackage

[design/bsd_front.sv]
module bsd_front #(
  parameter int W = bsd_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [3*W-1:0]    point,
  input  logic [3*W-1:0]    corner,
  input  logic [3*W-4:0]    extent,
  output logic              q_valid,
  output logic [2*W-1:0]    q,
  output logic [W+1:0]      tag
);
  import bsd_pkg::*;

  localparam int MW = W + 2;
  localparam int DW = W + 3;

  // stage A: doubled magnitude from centre per axis
  logic            va_r;
  logic [MW-1:0]   ma_r [3];
  logic [W-2:0]    sa_r [3];
  // stage B: excess, gap, inside
  logic            vb_r, inb_r, satb_r;
  logic [W-1:0]    eb_r [3];
  logic [W-2:0]    gb_r [3];
  // stage C: squares and smallest gap
  logic            vc_r, inc_r, satc_r;
  logic [2*W-1:0]  sqc_r [3];
  logic [W-2:0]    gc_r;
  // stage D
  logic            vd_r, ind_r, satd_r;
  logic [2*W-1:0]  qd_r;
  logic [W-1:0]    resd_r;

  logic [MW-1:0]   m_nxt [3];
  logic [MW-1:0]   ex_nxt [3];
  logic [W-2:0]    g_nxt [3];
  logic            in_nxt, sat_nxt;
  logic [W-2:0]    gmin_nxt;
  logic [2*W+1:0]  sum_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [DW-1:0] d;
      d = ({{3{point[i*W+W-1]}}, point[i*W +: W]} <<< 1)
        - ({{3{corner[i*W+W-1]}}, corner[i*W +: W]} <<< 1)
        - DW'(extent[i*(W-1) +: W-1]);
      m_nxt[i] = d[DW-1] ? MW'(-d) : MW'(d);
    end
    in_nxt = 1'b1;
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      logic [MW-1:0] sx;
      sx = MW'(sa_r[i]);
      if (ma_r[i] > sx) in_nxt = 1'b0;
      ex_nxt[i] = (ma_r[i] > sx) ? (ma_r[i] - sx) : '0;
      g_nxt[i]  = (W-1)'(sx - ma_r[i]);
      if (ex_nxt[i][MW-1:W] != '0) sat_nxt = 1'b1;
    end
    gmin_nxt = gb_r[0];
    if (gb_r[1] < gmin_nxt) gmin_nxt = gb_r[1];
    if (gb_r[2] < gmin_nxt) gmin_nxt = gb_r[2];
    sum_nxt = (2*W+2)'(sqc_r[0]) + (2*W+2)'(sqc_r[1]) + (2*W+2)'(sqc_r[2]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ma_r[i]  <= m_nxt[i];
        sa_r[i]  <= extent[i*(W-1) +: W-1];
        eb_r[i]  <= ex_nxt[i][W-1:0];
        gb_r[i]  <= g_nxt[i];
        sqc_r[i] <= (2*W)'(eb_r[i]) * (2*W)'(eb_r[i]);
      end
      inb_r  <= in_nxt;
      satb_r <= sat_nxt;
      inc_r  <= inb_r;
      satc_r <= satb_r;
      gc_r   <= gmin_nxt;
      ind_r  <= inc_r;
      satd_r <= satc_r;
      qd_r   <= sum_nxt[2*W+1:2];
      resd_r <= W'(0) - W'(gc_r[W-2:1]);
    end
  end

  assign q_valid = vd_r;
  assign q       = qd_r;
  assign tag     = {ind_r, satd_r, resd_r};

endmodule

[design/bsd_isqrt.sv]
module bsd_isqrt #(
  parameter int W  = bsd_pkg::COORD_WIDTH_DEF,
  parameter int TW = bsd_pkg::COORD_WIDTH_DEF + 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W-1:0] q,
  input  logic [TW-1:0]  tag_in,
  output logic           out_valid,
  output logic [W-1:0]   root,
  output logic [TW-1:0]  tag_out
);
  import bsd_pkg::*;

  localparam int RW = W + 2;
  localparam int XW = W + 4;

  // one root bit per stage, restoring digit recurrence
  logic            v_r    [W];
  logic [RW-1:0]   rem_r  [W];
  logic [W-1:0]    root_r [W];
  logic [2*W-1:0]  q_r    [W];
  logic [TW-1:0]   tag_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic           vi;
    logic [RW-1:0]  remi;
    logic [W-1:0]   rooti;
    logic [2*W-1:0] qi;
    logic [TW-1:0]  tagi;
    logic [XW-1:0]  sh, trial;
    logic           take;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign remi = '0;
      assign rooti = '0;
      assign qi = q;
      assign tagi = tag_in;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign remi = rem_r[k-1];
      assign rooti = root_r[k-1];
      assign qi = q_r[k-1];
      assign tagi = tag_r[k-1];
    end

    always_comb begin
      sh    = {remi, qi[2*W-1 -: 2]};
      trial = {2'b00, rooti, 2'b01};
      take  = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? RW'(sh - trial) : RW'(sh);
        root_r[k] <= {rooti[W-2:0], take};
        q_r[k]    <= {qi[2*W-3:0], 2'b00};
        tag_r[k]  <= tagi;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign root      = root_r[W-1];
  assign tag_out   = tag_r[W-1];

endmodule

[design/box_signed_distance.sv]
// Signed distance from a 3D point to an axis-aligned box.
// Config: write corner (signed) and extent (unsigned, COORD_WIDTH-1 bits)
// through cfg_we/cfg_index/cfg_data while no beats are in flight.
// Input channel: one beat carries point_x/y/z, taken when in_valid is high
// and in_stall is low. Output channel: one beat per input with
// out_signed_distance (negative inside), out_is_inside and out_saturated.
// Pipeline: 4 front stages, one stage per root bit of the square root,
// one output register. Throughput: one beat per cycle while no result
// waits on out_stall; the pipeline depth is set by the bit-per-stage
// square root.
// Reset (rst_n low, synchronous) clears all valid bits and zeroes the box.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
module box_signed_distance #(
  parameter int COORD_WIDTH = bsd_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [COORD_WIDTH-1:0]        in_point_x,
  input  logic [COORD_WIDTH-1:0]        in_point_y,
  input  logic [COORD_WIDTH-1:0]        in_point_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_WIDTH-1:0]        out_signed_distance,
  output logic                          out_is_inside,
  output logic                          out_saturated
);
  import bsd_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int TW = W + 2;

  logic [W-1:0]   corner_x_r, corner_y_r, corner_z_r;
  logic [W-2:0]   extent_x_r, extent_y_r, extent_z_r;
  logic           en;
  logic           qv, sv;
  logic [2*W-1:0] q;
  logic [TW-1:0]  tag_q, tag_s;
  logic [W-1:0]   root;
  logic           out_valid_r, inside_r, sat_r;
  logic [W-1:0]   dist_r;
  logic [W-1:0]   dist_nxt;
  logic           sat_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_x_r <= '0;
      corner_y_r <= '0;
      corner_z_r <= '0;
      extent_x_r <= '0;
      extent_y_r <= '0;
      extent_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CORNER_X: corner_x_r <= cfg_data;
        REG_CORNER_Y: corner_y_r <= cfg_data;
        REG_CORNER_Z: corner_z_r <= cfg_data;
        REG_EXTENT_X: extent_x_r <= cfg_data[W-2:0];
        REG_EXTENT_Y: extent_y_r <= cfg_data[W-2:0];
        REG_EXTENT_Z: extent_z_r <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // global advance: freeze only when a result waits on a stalled receiver
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  bsd_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .point    ({in_point_z, in_point_y, in_point_x}),
    .corner   ({corner_z_r, corner_y_r, corner_x_r}),
    .extent   ({extent_z_r, extent_y_r, extent_x_r}),
    .q_valid  (qv),
    .q        (q),
    .tag      (tag_q)
  );

  bsd_isqrt #(.W(W), .TW(TW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (qv),
    .q         (q),
    .tag_in    (tag_q),
    .out_valid (sv),
    .root      (root),
    .tag_out   (tag_s)
  );

  // result select and saturation
  always_comb begin
    if (tag_s[W+1]) begin
      dist_nxt = tag_s[W-1:0];
      sat_nxt  = 1'b0;
    end else if (tag_s[W] || root[W-1]) begin
      dist_nxt = {1'b0, {(W-1){1'b1}}};
      sat_nxt  = 1'b1;
    end else begin
      dist_nxt = root;
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r   <= dist_nxt;
      inside_r <= tag_s[W+1];
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_signed_distance = dist_r;
  assign out_is_inside       = inside_r;
  assign out_saturated       = sat_r;

endmodule

[tb/box_signed_distance_test.sv]
module box_signed_distance_test;
  import bsd_pkg::*;

  localparam int CW = 32;
  localparam int LATENCY = CW + 5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic [CW-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] MIN_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic [CW-1:0] distance;
    logic          in_box;
    logic          sat;
  } dist_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CW-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CW-1:0] out_signed_distance;
  logic out_is_inside, out_saturated;

  // box held by the predictor
  logic [CW-1:0]   box_corner [3];
  logic [CW-2:0]   box_extent [3];

  point_t     point_queue [$];
  dist_beat_t dist_expected [$];
  int         error_count = 0;
  int         pct_idle = 0, pct_stall = 0;

  box_signed_distance #(.COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_signed_distance(out_signed_distance),
    .out_is_inside(out_is_inside), .out_saturated(out_saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // doubled offset magnitude from the box centre on one axis
  function automatic longint axis_offset(logic [CW-1:0] p, logic [CW-1:0] c,
                                         logic [CW-2:0] s);
    longint d;
    d = 2 * longint'($signed(p)) - 2 * longint'($signed(c)) - longint'(s);
    return d < 0 ? -d : d;
  endfunction

  function automatic dist_beat_t box_distance(point_t pt);
    dist_beat_t res;
    longint m [3];
    longint s [3];
    longint ex, gap;
    logic [67:0] sum_sq, cand;
    logic [63:0] root;
    m[0] = axis_offset(pt.x, box_corner[0], box_extent[0]);
    m[1] = axis_offset(pt.y, box_corner[1], box_extent[1]);
    m[2] = axis_offset(pt.z, box_corner[2], box_extent[2]);
    res.in_box = 1'b1;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'(box_extent[i]);
      if (m[i] > s[i]) res.in_box = 1'b0;
    end
    if (res.in_box) begin
      gap = s[0] - m[0];
      for (int i = 1; i < 3; i++)
        if (s[i] - m[i] < gap) gap = s[i] - m[i];
      res.distance = CW'(-(gap >>> 1));
    end else begin
      sum_sq = '0;
      for (int i = 0; i < 3; i++) begin
        ex = m[i] > s[i] ? m[i] - s[i] : 0;
        if (ex >= (longint'(1) << CW)) res.sat = 1'b1;
        sum_sq += 68'(ex) * 68'(ex);
      end
      if (!res.sat) begin
        // quarter of the doubled-unit sum, then bitwise square root
        sum_sq = sum_sq >> 2;
        root = '0;
        for (int b = CW - 1; b >= 0; b--) begin
          cand = 68'(root | (64'd1 << b));
          if (cand * cand <= sum_sq) root = cand[63:0];
        end
        if (root > 64'(MAX_POS)) res.sat = 1'b1;
        else res.distance = root[CW-1:0];
      end
      if (res.sat) res.distance = MAX_POS;
    end
    return res;
  endfunction

  // driver: one beat per handshake, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        dist_expected.push_back(box_distance({in_point_x, in_point_y, in_point_z}));
      if (!in_valid || !in_stall) begin
        if (point_queue.size() > 0 && $urandom_range(99) >= pct_idle) begin
          point_t pt;
          pt = point_queue.pop_front();
          in_point_x <= pt.x;
          in_point_y <= pt.y;
          in_point_z <= pt.z;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dist_expected.size() == 0) begin
          $display("%0t: unexpected beat dist=%h inside=%b sat=%b", $time,
                   out_signed_distance, out_is_inside, out_saturated);
          error_count++;
        end else begin
          dist_beat_t exp_beat;
          exp_beat = dist_expected.pop_front();
          if (out_signed_distance !== exp_beat.distance) begin
            $display("%0t: distance expected %h actual %h", $time,
                     exp_beat.distance, out_signed_distance);
            error_count++;
          end
          if (out_is_inside !== exp_beat.in_box) begin
            $display("%0t: is_inside expected %b actual %b", $time,
                     exp_beat.in_box, out_is_inside);
            error_count++;
          end
          if (out_saturated !== exp_beat.sat) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_beat.sat, out_saturated);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < pct_stall);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_CORNER_X: box_corner[0] = data;
      REG_CORNER_Y: box_corner[1] = data;
      REG_CORNER_Z: box_corner[2] = data;
      REG_EXTENT_X: box_extent[0] = data[CW-2:0];
      REG_EXTENT_Y: box_extent[1] = data[CW-2:0];
      REG_EXTENT_Z: box_extent[2] = data[CW-2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_box(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                          logic [CW-1:0] ex, logic [CW-1:0] ey, logic [CW-1:0] ez);
    write_reg(REG_CORNER_X, cx);
    write_reg(REG_CORNER_Y, cy);
    write_reg(REG_CORNER_Z, cz);
    write_reg(REG_EXTENT_X, ex);
    write_reg(REG_EXTENT_Y, ey);
    write_reg(REG_EXTENT_Z, ez);
    write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
  endtask

  task automatic drain();
    while (point_queue.size() > 0 || dist_expected.size() > 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // one coordinate: mostly near the box on that axis, some extremes and noise
  function automatic logic [CW-1:0] pick_coord(int axis);
    logic [CW-1:0] span;
    span = {1'b0, box_extent[axis]};
    case ($urandom_range(9))
      0: return $urandom_range(1) ? MAX_POS : MIN_NEG;
      1: return $urandom;
      2: return box_corner[axis] + ($urandom_range(1) ? span : '0);
      3: return box_corner[axis] + span + CW'($urandom_range(255)) - 32'd128;
      default: begin
        if (span == '0) return box_corner[axis] + CW'($urandom_range(7)) - 32'd3;
        return box_corner[axis] + CW'($urandom_range(span)) - (span >> 3);
      end
    endcase
  endfunction

  task automatic run_phase(int phase, int count);
    point_t pt;
    case (phase % 4)
      0: begin pct_idle = 0;  pct_stall = 0;  end
      1: begin pct_idle = 48; pct_stall = 0;  end
      2: begin pct_idle = 0;  pct_stall = 48; end
      default: begin pct_idle = 9; pct_stall = 9; end
    endcase
    for (int i = 0; i < count; i++) begin
      pt.x = pick_coord(0);
      pt.y = pick_coord(1);
      pt.z = pick_coord(2);
      point_queue.push_back(pt);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      box_corner[i] = '0;
      box_extent[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset box (all zero), centre and extremes
    point_queue.push_back('{'0, '0, '0});
    point_queue.push_back('{MAX_POS, MAX_POS, MAX_POS});
    point_queue.push_back('{MIN_NEG, MIN_NEG, MIN_NEG});
    point_queue.push_back('{MAX_POS, MIN_NEG, 32'h0001_0000});
    point_queue.push_back('{32'h0000_0001, '0, '0});
    drain();

    // widest box from the lowest corner; top data bit set on extents
    load_box(MIN_NEG, MIN_NEG, MIN_NEG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    point_queue.push_back('{MAX_POS, MAX_POS, MAX_POS});
    point_queue.push_back('{MIN_NEG, MIN_NEG, MIN_NEG});
    point_queue.push_back('{'0, '0, '0});
    point_queue.push_back('{32'hFFFF_FFFF, '0, 32'h4000_0000});
    drain();

    // flat box at the top corner: some distances beyond the output range
    load_box(MAX_POS, MAX_POS, MAX_POS, '0, '0, '0);
    point_queue.push_back('{MIN_NEG, MIN_NEG, MIN_NEG});
    point_queue.push_back('{MAX_POS, MAX_POS, MAX_POS});
    point_queue.push_back('{MIN_NEG, MAX_POS, MAX_POS});
    point_queue.push_back('{'0, '0, '0});
    point_queue.push_back('{32'h7FFF_FFFE, MAX_POS, MAX_POS});
    drain();

    // small box, points at corners, inside and outside
    load_box('0, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'h0000_0003);
    point_queue.push_back('{'0, '0, '0});
    point_queue.push_back('{32'h0001_0000, 32'h0002_0000, 32'h0000_0003});
    point_queue.push_back('{32'h0000_8000, 32'h0001_0000, 32'h0000_0001});
    point_queue.push_back('{32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001});
    point_queue.push_back('{32'h0003_0000, 32'h0005_0000, 32'h0000_0010});
    point_queue.push_back('{MIN_NEG, MAX_POS, '0});
    drain();

    // random part across several boxes, idle and stall patterns
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 5)
        0: load_box($urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
                    $urandom_range(2047) - 1024, $urandom_range(1 << 20),
                    $urandom_range(1 << 20), $urandom_range(1 << 20));
        1: load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: load_box(MIN_NEG, $urandom, MAX_POS, 32'hFFFF_FFFF, '0, $urandom);
        3: load_box($urandom, $urandom, $urandom, '0, $urandom_range(15), $urandom);
        default: load_box($urandom_range(1) ? MAX_POS : MIN_NEG, $urandom, $urandom,
                          MAX_POS, $urandom_range(1 << 24), $urandom_range(1));
      endcase
      run_phase(ph, 125);
    end

    if (error_count == 0) begin
      $display("PASS box_signed_distance");
    end else begin
      $display("FAIL box_signed_distance");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL box_signed_distance");
    $finish;
  end

endmodule
